// File: design/pfpa_pkg.sv
`default_nettype none

package pfpa_pkg;

  // stream and register port widths
  localparam int OPCODE_W    = 2;
  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 15;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_OOM  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] STS_NULL = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MEMORY_TOP  = 2'd0;
  localparam logic [1:0] REG_IMAGE_START = 2'd1;
  localparam logic [1:0] REG_IMAGE_END   = 2'd2;
  localparam logic [1:0] REG_HOLE_END    = 2'd3;

  // register reset values
  localparam logic [ADDR_W-1:0] RST_MEMORY_TOP  = 32'h0400_0000;
  localparam logic [ADDR_W-1:0] RST_IMAGE_START = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] RST_IMAGE_END   = 32'h0020_0000;
  localparam logic [ADDR_W-1:0] RST_HOLE_END    = 32'h0010_0000;

  typedef struct packed {
    logic [ADDR_W-1:0] memory_top;
    logic [ADDR_W-1:0] image_start;
    logic [ADDR_W-1:0] image_end;
    logic [ADDR_W-1:0] hole_end;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_WALK
  } state_t;

endpackage

`default_nettype wire

// File: design/pfpa_ram.sv
`default_nettype none

module pfpa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: design/pfpa_regs.sv
`default_nettype none

module pfpa_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfpa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [pfpa_pkg::PDATA_W-1:0]  pwdata,
  output      logic [pfpa_pkg::PDATA_W-1:0]  prdata,
  output      logic                          pready,
  output      pfpa_pkg::cfg_t                cfg
);

  logic       wr_stb;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_stb  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.memory_top  <= pfpa_pkg::RST_MEMORY_TOP;
      cfg.image_start <= pfpa_pkg::RST_IMAGE_START;
      cfg.image_end   <= pfpa_pkg::RST_IMAGE_END;
      cfg.hole_end    <= pfpa_pkg::RST_HOLE_END;
    end else if (wr_stb) begin
      case (reg_idx)
        pfpa_pkg::REG_MEMORY_TOP:  cfg.memory_top  <= pwdata;
        pfpa_pkg::REG_IMAGE_START: cfg.image_start <= pwdata;
        pfpa_pkg::REG_IMAGE_END:   cfg.image_end   <= pwdata;
        pfpa_pkg::REG_HOLE_END:    cfg.hole_end    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pfpa_pkg::REG_MEMORY_TOP:  prdata = cfg.memory_top;
      pfpa_pkg::REG_IMAGE_START: prdata = cfg.image_start;
      pfpa_pkg::REG_IMAGE_END:   prdata = cfg.image_end;
      pfpa_pkg::REG_HOLE_END:    prdata = cfg.hole_end;
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/pfpa_ctrl.sv
`default_nettype none

module pfpa_ctrl #(
  parameter int STORE_DEPTH = 16384,
  parameter int PAGE_BYTES  = 4096,
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES),
  localparam int PFN_W      = pfpa_pkg::ADDR_W - PAGE_SHIFT,
  localparam int PTR_W      = $clog2(STORE_DEPTH)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pfpa_pkg::cfg_t                    cfg,
  // request side
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [pfpa_pkg::OPCODE_W-1:0]     in_opcode,
  input  wire logic [pfpa_pkg::ADDR_W-1:0]       in_addr,
  // result side
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [pfpa_pkg::STATUS_W-1:0]     out_status,
  output      logic [pfpa_pkg::ADDR_W-1:0]       out_granted,
  output      logic [pfpa_pkg::COUNT_OUT_W-1:0]  out_count,
  // frame store port
  output      logic                              wr_en,
  output      logic [PTR_W-1:0]                  wr_addr,
  output      logic [PFN_W-1:0]                  wr_data,
  output      logic                              rd_en,
  output      logic [PTR_W-1:0]                  rd_addr,
  input  wire logic [PFN_W-1:0]                  rd_data
);

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int WALK_W = PFN_W + 1;
  localparam int WADR_W = WALK_W + PAGE_SHIFT;

  pfpa_pkg::state_t state, state_next;

  logic [pfpa_pkg::OPCODE_W-1:0] op_reg;
  logic [pfpa_pkg::ADDR_W-1:0]   addr_reg;

  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [WALK_W-1:0] walk_pfn, walk_next;

  logic [WALK_W-1:0] kend_pfn, hole_pfn, start_pfn;
  logic [WADR_W-1:0] walk_addr;
  logic              in_range, in_kernel, not_full, walk_go, pool_empty, out_free;

  logic                          res_load;
  logic [pfpa_pkg::STATUS_W-1:0] res_status;
  logic [pfpa_pkg::ADDR_W-1:0]   res_granted;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  // first page of the init walk: round both bounds up, take the higher
  assign kend_pfn  = WALK_W'(cfg.image_end >> PAGE_SHIFT)
                   + WALK_W'(|cfg.image_end[PAGE_SHIFT-1:0]);
  assign hole_pfn  = WALK_W'(cfg.hole_end >> PAGE_SHIFT)
                   + WALK_W'(|cfg.hole_end[PAGE_SHIFT-1:0]);
  assign start_pfn = (hole_pfn > kend_pfn) ? hole_pfn : kend_pfn;

  assign walk_addr  = {walk_pfn, {PAGE_SHIFT{1'b0}}};
  assign in_range   = walk_addr < WADR_W'(cfg.memory_top);
  assign in_kernel  = (walk_addr >= WADR_W'(cfg.image_start))
                   && (walk_addr < WADR_W'(cfg.image_end));
  assign not_full   = cnt < CNT_W'(STORE_DEPTH);
  assign walk_go    = in_range && not_full;
  assign pool_empty = (cnt == '0);
  assign out_free   = !out_valid || out_ready;

  assign in_ready = (state == pfpa_pkg::ST_IDLE);
  assign wr_addr  = wr_ptr;
  assign rd_addr  = rd_ptr;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pfpa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = pfpa_pkg::ST_EXEC;
        end
      end
      pfpa_pkg::ST_EXEC: begin
        if (op_reg == pfpa_pkg::OP_INIT) begin
          state_next = pfpa_pkg::ST_WALK;
        end else if (op_reg == pfpa_pkg::OP_ALLOC && !pool_empty) begin
          state_next = pfpa_pkg::ST_READ;
        end else if (out_free) begin
          state_next = pfpa_pkg::ST_IDLE;
        end
      end
      pfpa_pkg::ST_READ: begin
        if (out_free) begin
          state_next = pfpa_pkg::ST_IDLE;
        end
      end
      pfpa_pkg::ST_WALK: begin
        if (!walk_go && out_free) begin
          state_next = pfpa_pkg::ST_IDLE;
        end
      end
      default: state_next = pfpa_pkg::ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    wr_en       = 1'b0;
    wr_data     = addr_reg[pfpa_pkg::ADDR_W-1:PAGE_SHIFT];
    rd_en       = 1'b0;
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    cnt_next    = cnt;
    walk_next   = walk_pfn;
    res_load    = 1'b0;
    res_status  = pfpa_pkg::STS_OK;
    res_granted = '0;
    case (state)
      pfpa_pkg::ST_EXEC: begin
        case (op_reg)
          pfpa_pkg::OP_INIT: begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            cnt_next    = '0;
            walk_next   = start_pfn;
          end
          pfpa_pkg::OP_ALLOC: begin
            if (!pool_empty) begin
              rd_en       = 1'b1;
              rd_ptr_next = ptr_inc(rd_ptr);
              cnt_next    = cnt - 1'b1;
            end else if (out_free) begin
              res_load   = 1'b1;
              res_status = pfpa_pkg::STS_OOM;
            end
          end
          pfpa_pkg::OP_FREE: begin
            if (out_free) begin
              res_load = 1'b1;
              if (addr_reg == '0) begin
                res_status = pfpa_pkg::STS_NULL;
              end else if (not_full) begin
                wr_en       = 1'b1;
                wr_ptr_next = ptr_inc(wr_ptr);
                cnt_next    = cnt + 1'b1;
              end else begin
                res_status = pfpa_pkg::STS_FULL;
              end
            end
          end
          default: begin
            res_load = out_free;
          end
        endcase
      end
      pfpa_pkg::ST_READ: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_granted = {rd_data, {PAGE_SHIFT{1'b0}}};
        end
      end
      pfpa_pkg::ST_WALK: begin
        wr_data = walk_pfn[PFN_W-1:0];
        if (walk_go) begin
          walk_next = walk_pfn + 1'b1;
          if (!in_kernel) begin
            wr_en       = 1'b1;
            wr_ptr_next = ptr_inc(wr_ptr);
            cnt_next    = cnt + 1'b1;
          end
        end else if (out_free) begin
          res_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfpa_pkg::ST_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      cnt    <= cnt_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_pfn <= walk_next;
    if (in_valid && in_ready) begin
      op_reg   <= in_opcode;
      addr_reg <= in_addr;
    end
    if (res_load) begin
      out_status  <= res_status;
      out_granted <= res_granted;
      out_count   <= pfpa_pkg::COUNT_OUT_W'(cnt_next);
    end
  end

  // pool never holds more frames than the store has entries
  assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(STORE_DEPTH))
    else $error("pool count above store depth");

  // an empty or a full pool has its two pointers on the same entry
  assert property (@(posedge clk) disable iff (rst)
    (cnt == '0 || cnt == CNT_W'(STORE_DEPTH)) |-> (rd_ptr == wr_ptr))
    else $error("queue pointers disagree with pool count");

  // the store is never written and read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("frame store read and write overlap");

  // read data is only used after a read was issued
  assert property (@(posedge clk) disable iff (rst)
    (state == pfpa_pkg::ST_READ) |-> ($past(rd_en) || $past(state == pfpa_pkg::ST_READ)))
    else $error("grant taken without a store read");

  // a result is never loaded over one that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_status) && $stable(out_count)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: design/page_frame_pool_allocator.sv
`default_nettype none
// sequence: a request is decoded in the exec state, where free, opcode 3 and empty alloc load
//   their result; alloc reads the store there and loads the grant in the read state; init walks
//   pages from the start page upward; one request in flight, paced by the control sequencer;
//   a new request is taken while a result waits
// reset (synchronous, active high): pool empty, both pointers at entry 0, registers at
//   their defaults; frame store contents are not cleared and need no clearing pass
module page_frame_pool_allocator #(
  parameter int STORE_DEPTH = 16384,
  parameter int PAGE_BYTES  = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // register port
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [pfpa_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [pfpa_pkg::PDATA_W-1:0]         pwdata,
  output      logic [pfpa_pkg::PDATA_W-1:0]         prdata,
  output      logic                                 pready,
  // request words
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  input  wire logic [pfpa_pkg::IN_TDATA_W-1:0]      s_tdata,  // opcode[1:0], page_address[33:2]
  // result words
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  output      logic [pfpa_pkg::OUT_TDATA_W-1:0]     m_tdata   // status[1:0], granted_address[33:2],
                                                              // free_count[48:34]
);

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PFN_W      = pfpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int PTR_W      = $clog2(STORE_DEPTH);
  localparam int PAD_W      = pfpa_pkg::OUT_TDATA_W - pfpa_pkg::COUNT_OUT_W
                            - pfpa_pkg::ADDR_W - pfpa_pkg::STATUS_W;

  pfpa_pkg::cfg_t cfg;

  // frame store port
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PFN_W-1:0] wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [PFN_W-1:0] rd_data;

  // unpacked request and result fields
  logic [pfpa_pkg::OPCODE_W-1:0]    in_opcode;
  logic [pfpa_pkg::ADDR_W-1:0]      in_addr;
  logic [pfpa_pkg::STATUS_W-1:0]    out_status;
  logic [pfpa_pkg::ADDR_W-1:0]      out_granted;
  logic [pfpa_pkg::COUNT_OUT_W-1:0] out_count;

  assign in_opcode = s_tdata[1:0];
  assign in_addr   = s_tdata[33:2];
  assign m_tdata   = {{PAD_W{1'b0}}, out_count, out_granted, out_status};

  // configuration registers: memory top, kernel image bounds, low hole end
  pfpa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: request decode, queue pointers, init walk, result register
  pfpa_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_opcode   (in_opcode),
    .in_addr     (in_addr),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_granted (out_granted),
    .out_count   (out_count),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // circular queue of free page frame numbers; reads and writes never
  // target the same cycle, so no forwarding is needed
  pfpa_ram #(
    .WIDTH (PFN_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
